// ----- rtl/sal_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the shifting array list.
// No dependencies; every other file imports this package.
package sal_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = 5;
   localparam int LEN_W    = 5;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type               op;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } cell_ctrl_type;

endpackage

// ----- rtl/sal_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: command, position and value with valid/ready.
// Depends on sal_pkg.
interface sal_req_if;
   import sal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

// ----- rtl/sal_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: status, data and length with valid/ready.
// Depends on sal_pkg.
interface sal_rsp_if;
   import sal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] data;
   logic [LEN_W-1:0]         length;

   modport source (output valid, status, data, length, input ready);
   modport sink   (input valid, status, data, length, output ready);
endinterface

// ----- rtl/shifting_array_list_unit.sv -----
`timescale 1ns / 1ps
// Shifting array list: an ordered list of up to CAPACITY signed 32-bit entries
// held in a row of cells, one entry per cell. Insert at a position moves every
// entry at or above it up one cell, delete of the first entry moves every
// entry down one cell, and read returns the entry at an index through a
// selector over the cell outputs. Every transaction on the request
// channel yields exactly one response transaction carrying a status, the read
// data (zero unless an accepted read) and the length after the command.
// Rejected commands (full, empty, out of range, unused code) change nothing.
// Throughput is one command per clock: every cell updates in parallel on the
// edge that accepts the command, and the response lands in an output register
// on that same edge. The request side stalls only while a response sits in the
// output register and the sink does not take it.
// No clearing pass follows reset; reset only empties the list.
// Depends on sal_pkg, sal_req_if, sal_rsp_if and sal_cell.
module shifting_array_list_unit (
   input  logic     clock,
   input  logic     reset,
   sal_req_if.sink  req_chan,
   sal_rsp_if.source rsp_chan
);
   import sal_pkg::*;

   // Control and status registers.
   logic [LEN_W-1:0]         count_ff;
   logic [LEN_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [STAT_W-1:0]        rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic signed [DATA_W-1:0] rsp_data_in;
   logic [LEN_W-1:0]         rsp_length_ff;

   logic                     accept;
   logic                     full;
   logic                     empty;
   cell_ctrl_type            ctrl;
   cell_op_type              op_sel;
   logic signed [DATA_W-1:0] entry_q [CAPACITY];

   // Take a new command whenever the output register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full  = (count_ff == LEN_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Decode the command against the current length.
   always_comb begin
      op_sel        = CELL_HOLD;
      rsp_status_in = ST_RANGE;
      rsp_data_in   = '0;
      count_in      = count_ff;
      unique case (req_chan.command)
         CMD_INSERT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else if (req_chan.position > count_ff) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_status_in = ST_OK;
               op_sel        = CELL_INSERT;
               count_in      = count_ff + LEN_W'(1);
            end
         end
         CMD_DELETE: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_status_in = ST_OK;
               op_sel        = CELL_DELETE;
               count_in      = count_ff - LEN_W'(1);
            end
         end
         CMD_READ: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else if (req_chan.position >= count_ff) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_status_in = ST_OK;
               rsp_data_in   = entry_q[req_chan.position[IDX_W-1:0]];
            end
         end
         default: begin
            rsp_status_in = ST_RANGE;
         end
      endcase
   end

   // Broadcast to the row; hold every cell unless a command is taken.
   always_comb begin
      ctrl.op       = accept ? op_sel : CELL_HOLD;
      ctrl.position = req_chan.position;
      ctrl.value    = req_chan.value;
   end

   // Row of cells; each reads its left and right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_left
         assign left_entry = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = entry_q[i+1];
      end

      sal_cell u_cell (
         .clock       (clock),
         .index       (IDX_W'(i)),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_q[i])
      );
   end

   // Response valid: set on accept, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= accept ? count_in : count_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the response; loaded only with a new transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_length_ff <= count_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.length = rsp_length_ff;

   // Length never exceeds the row size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(CAPACITY))
      else $error("list length exceeds capacity");

   // An accepted insert grows the list by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && op_sel == CELL_INSERT |=> count_ff == $past(count_ff) + LEN_W'(1))
      else $error("insert did not grow the list by one");

   // Every accepted command leaves a response waiting next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command produced no response");

   // Nonzero data only accompanies an ok status.
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff != '0 |-> rsp_status_ff == ST_OK)
      else $error("data returned with a rejected status");

   // Response length matches the held length.
   a_len_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_length_ff == count_ff)
      else $error("response length differs from list length");
endmodule

// ----- rtl/sal_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list row: holds one entry and takes its
// neighbor's entry on a shift. Depends on sal_pkg.
module sal_cell (
   input  logic                              clock,
   input  logic [sal_pkg::IDX_W-1:0]         index,
   input  sal_pkg::cell_ctrl_type            ctrl,
   input  logic signed [sal_pkg::DATA_W-1:0] left_entry,
   input  logic signed [sal_pkg::DATA_W-1:0] right_entry,
   output logic signed [sal_pkg::DATA_W-1:0] entry
);
   import sal_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [POS_W-1:0]         index_ext;

   assign index_ext = POS_W'(index);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            // Load at the slot, move up above it, hold below it.
            if (index_ext == ctrl.position) begin
               entry_in = ctrl.value;
            end else if (index_ext > ctrl.position) begin
               entry_in = left_entry;
            end
         end
         CELL_DELETE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
